>>> src/sawc_pkg.sv
package sawc_pkg;
    localparam logic [1:0] CMD_PROBE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_FILL  = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [19:0] tag;
        logic [5:0]  set_index;
        logic        kind;
        logic [63:0] block_data;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic        error;
        logic [63:0] read_data;
        logic        read_dirty;
        logic        evict_valid;
        logic        evict_kind;
        logic [19:0] evict_tag;
        logic [63:0] evict_data;
    } t_rsp;
endpackage

>>> src/sawc_if.sv
interface sawc_req_if;
    logic              valid;
    logic              ready;
    sawc_pkg::t_req    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sawc_rsp_if;
    logic              valid;
    logic              ready;
    sawc_pkg::t_rsp    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> src/set_assoc_writeback_cache.sv
// set-associative write-back cache store with age-based replacement
// i_req: one transfer per request (probe, read, write, fill)
// o_rsp: one transfer per request, in request order
// a request is taken while the engine is idle; the set's tag row is read from
// a synchronous memory in the next cycle, then the result and the write-back
// of tag, age, dirty and data rows happen once the output register is empty or
// being taken; the next request waits for the single read-then-write pass over the set memories
// the result sits in an output register; the next request is taken while a
// result still waits, but a new result is not produced until it is taken
// reset: all valid bits (one per set and way, in flip-flops) clear at once,
// so no clearing pass is needed; the stale age and dirty bit of an invalid
// line are never used
// a stalled receiver simply holds the output register and the engine
// waits with the next request before its write-back
module set_assoc_writeback_cache #(
    parameter int NUM_WAYS   = 4,
    parameter int NUM_SETS   = 64,
    parameter int TAG_BITS   = 20,
    parameter int BLOCK_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sawc_req_if.sink    i_req,
    sawc_rsp_if.source  o_rsp
);
    import sawc_pkg::*;

    localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WW = $clog2(NUM_WAYS);
    localparam int AW = $clog2(NUM_WAYS);
    localparam logic [AW-1:0] AGE_MAX = AW'(NUM_WAYS - 1);

    typedef struct packed {
        logic               dirty;
        logic               kind;
        logic [TAG_BITS-1:0] tag;
        logic [AW-1:0]      age;
    } t_meta;

    t_meta               m_meta [NUM_SETS][NUM_WAYS];
    logic [BLOCK_BITS-1:0] m_data [NUM_SETS][NUM_WAYS];
    logic [NUM_WAYS-1:0] r_valid [NUM_SETS];

    t_meta               r_rd_meta [NUM_WAYS];
    logic [BLOCK_BITS-1:0] r_rd_data [NUM_WAYS];

    logic                r_busy;
    logic [1:0]          r_cmd;
    logic [TAG_BITS-1:0] r_tag;
    logic [SW-1:0]       r_set;
    logic                r_kind;
    logic [BLOCK_BITS-1:0] r_bdata;
    logic                r_ovalid;
    t_rsp                r_rsp;

    logic                take;
    logic                fin;
    logic [SW-1:0]       req_set;

    assign req_set     = SW'(i_req.payload.set_index % NUM_SETS);
    assign i_req.ready = !r_busy;
    assign take        = i_req.valid && !r_busy;
    assign fin         = r_busy && (!r_ovalid || o_rsp.ready);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.payload = r_rsp;

    // set read, registered when a request is taken
    always_ff @(posedge i_clk) begin
        if (take) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                r_rd_meta[w] <= m_meta[req_set][w];
                r_rd_data[w] <= m_data[req_set][w];
            end
            r_cmd   <= i_req.payload.cmd;
            r_tag   <= i_req.payload.tag[TAG_BITS-1:0];
            r_set   <= req_set;
            r_kind  <= i_req.payload.kind;
            r_bdata <= i_req.payload.block_data[BLOCK_BITS-1:0];
        end
    end

    logic [NUM_WAYS-1:0] vld;
    logic                hit;
    logic [WW-1:0]       mw;
    logic                has_inv;
    logic [WW-1:0]       iw;
    logic [WW-1:0]       aw;
    logic [AW-1:0]       best;
    logic [WW-1:0]       sel;
    logic                upd;
    t_rsp                n_rsp;

    always_comb begin
        vld = r_valid[r_set];
        hit = 1'b0;
        mw = '0;
        has_inv = 1'b0;
        iw = '0;
        aw = '0;
        best = AGE_MAX;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (vld[w] && r_rd_meta[w].tag == r_tag && r_rd_meta[w].kind == r_kind) begin
                hit = 1'b1;
                mw = WW'(w);
            end
            if (!vld[w]) begin
                has_inv = 1'b1;
                iw = WW'(w);
            end
        end
        // invalid lines carry stale ages but are never chosen here since has_inv wins
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (r_rd_meta[w].age < best) begin
                best = r_rd_meta[w].age;
                aw = WW'(w);
            end
        end
        sel = (r_cmd == CMD_FILL) ? (has_inv ? iw : aw) : mw;
        upd = (r_cmd == CMD_FILL) || ((r_cmd == CMD_READ || r_cmd == CMD_WRITE) && hit);
        n_rsp = '0;
        n_rsp.hit = hit;
        n_rsp.error = (r_cmd == CMD_READ || r_cmd == CMD_WRITE) && !hit;
        if (r_cmd == CMD_READ && hit) begin
            n_rsp.read_data  = 64'(r_rd_data[mw]);
            n_rsp.read_dirty = r_rd_meta[mw].dirty;
        end
        if (r_cmd == CMD_FILL && vld[sel] && r_rd_meta[sel].dirty) begin
            n_rsp.evict_valid = 1'b1;
            n_rsp.evict_kind  = r_rd_meta[sel].kind;
            n_rsp.evict_tag   = 20'(r_rd_meta[sel].tag);
            n_rsp.evict_data  = 64'(r_rd_data[sel]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin && upd) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                t_meta m;
                m = r_rd_meta[w];
                if (WW'(w) == sel) begin
                    m.age = AGE_MAX;
                    if (r_cmd == CMD_FILL) begin
                        m.dirty = 1'b0;
                        m.kind  = r_kind;
                        m.tag   = r_tag;
                    end else if (r_cmd == CMD_WRITE) begin
                        m.dirty = 1'b1;
                    end
                end else if (vld[w] && m.age != '0) begin
                    m.age = m.age - 1'b1;
                end
                m_meta[r_set][w] <= m;
            end
            if (r_cmd == CMD_FILL || r_cmd == CMD_WRITE)
                m_data[r_set][sel] <= r_bdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin)
            r_rsp <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int s = 0; s < NUM_SETS; s++)
                r_valid[s] <= '0;
        end else begin
            if (take)
                r_busy <= 1'b1;
            else if (fin)
                r_busy <= 1'b0;
            if (fin)
                r_ovalid <= 1'b1;
            else if (o_rsp.ready)
                r_ovalid <= 1'b0;
            if (fin && r_cmd == CMD_FILL)
                r_valid[r_set][sel] <= 1'b1;
        end
    end
endmodule

>>> test/tb_top.sv
module tb_top;
    import sawc_pkg::*;

    localparam int WAYS = 4;
    localparam int SETS = 64;
    localparam logic [1:0] AGE_TOP = 2'(WAYS - 1);

    logic i_clk;
    logic i_rst_n;

    sawc_req_if req_ch();
    sawc_rsp_if rsp_ch();

    set_assoc_writeback_cache u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // shadow copy of the cache arrays
    logic        sh_valid [SETS][WAYS];
    logic        sh_dirty [SETS][WAYS];
    logic        sh_kind  [SETS][WAYS];
    logic [19:0] sh_tag   [SETS][WAYS];
    logic [1:0]  sh_age   [SETS][WAYS];
    logic [63:0] sh_data  [SETS][WAYS];

    t_rsp rsp_pending[$];
    int   fail_cnt;
    bit   idle_on;
    bit   hold_rsp;
    int   hold_cycles;

    function automatic int lookup_way(int s, logic [19:0] tg, logic kd);
        for (int w = 0; w < WAYS; w++) begin
            if (sh_valid[s][w] && sh_tag[s][w] == tg && sh_kind[s][w] == kd) return w;
        end
        return -1;
    endfunction

    function automatic void make_youngest(int s, int way);
        for (int w = 0; w < WAYS; w++) begin
            if (w == way) sh_age[s][w] = AGE_TOP;
            else if (sh_valid[s][w] && sh_age[s][w] != 0) sh_age[s][w]--;
        end
    endfunction

    function automatic int choose_victim(int s);
        int way;
        logic [1:0] best;
        way = 0;
        best = AGE_TOP;
        for (int w = 0; w < WAYS; w++) begin
            if (!sh_valid[s][w]) return w;
        end
        for (int w = 0; w < WAYS; w++) begin
            if (sh_age[s][w] < best) begin
                best = sh_age[s][w];
                way = w;
            end
        end
        return way;
    endfunction

    function automatic t_rsp cache_access(t_req rq);
        t_rsp r;
        int s;
        int m;
        int v;
        r = '0;
        s = rq.set_index;
        m = lookup_way(s, rq.tag, rq.kind);
        r.hit = (m >= 0);
        case (rq.cmd)
            CMD_READ, CMD_WRITE: begin
                if (m < 0) begin
                    r.error = 1'b1;
                end else begin
                    if (rq.cmd == CMD_READ) begin
                        r.read_data = sh_data[s][m];
                        r.read_dirty = sh_dirty[s][m];
                    end else begin
                        sh_data[s][m] = rq.block_data;
                        sh_dirty[s][m] = 1'b1;
                    end
                    make_youngest(s, m);
                end
            end
            CMD_FILL: begin
                v = choose_victim(s);
                if (sh_valid[s][v] && sh_dirty[s][v]) begin
                    r.evict_valid = 1'b1;
                    r.evict_kind = sh_kind[s][v];
                    r.evict_tag = sh_tag[s][v];
                    r.evict_data = sh_data[s][v];
                end
                sh_valid[s][v] = 1'b1;
                sh_dirty[s][v] = 1'b0;
                sh_kind[s][v] = rq.kind;
                sh_tag[s][v] = rq.tag;
                sh_data[s][v] = rq.block_data;
                make_youngest(s, v);
            end
            default: ;
        endcase
        return r;
    endfunction

    // valid stays high after a transfer until the next item or a drain drops it
    task automatic send_req(logic [1:0] cmd, logic [19:0] tg, logic [5:0] s,
                            logic kd, logic [63:0] d);
        t_req rq;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        rq.cmd = cmd;
        rq.tag = tg;
        rq.set_index = s;
        rq.kind = kd;
        rq.block_data = d;
        req_ch.valid <= 1'b1;
        req_ch.payload <= rq;
        do @(posedge i_clk); while (!req_ch.ready);
        rsp_pending.push_back(cache_access(rq));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (rsp_pending.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand_block();
        return {$urandom, $urandom};
    endfunction

    // response ready: random bursts of stall, or a long hold on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles++;
        end else if (idle_on && hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles = $urandom_range(1, 9);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (rsp_pending.size() == 0) begin
                $error("unexpected response transfer");
                fail_cnt++;
            end else begin
                want = rsp_pending.pop_front();
                if (got.hit !== want.hit) begin
                    $error("hit exp %0h got %0h", want.hit, got.hit); fail_cnt++;
                end
                if (got.error !== want.error) begin
                    $error("error exp %0h got %0h", want.error, got.error); fail_cnt++;
                end
                if (got.read_data !== want.read_data) begin
                    $error("read_data exp %0h got %0h", want.read_data, got.read_data);
                    fail_cnt++;
                end
                if (got.read_dirty !== want.read_dirty) begin
                    $error("read_dirty exp %0h got %0h", want.read_dirty, got.read_dirty);
                    fail_cnt++;
                end
                if (got.evict_valid !== want.evict_valid) begin
                    $error("evict_valid exp %0h got %0h", want.evict_valid, got.evict_valid);
                    fail_cnt++;
                end
                if (got.evict_kind !== want.evict_kind) begin
                    $error("evict_kind exp %0h got %0h", want.evict_kind, got.evict_kind);
                    fail_cnt++;
                end
                if (got.evict_tag !== want.evict_tag) begin
                    $error("evict_tag exp %0h got %0h", want.evict_tag, got.evict_tag);
                    fail_cnt++;
                end
                if (got.evict_data !== want.evict_data) begin
                    $error("evict_data exp %0h got %0h", want.evict_data, got.evict_data);
                    fail_cnt++;
                end
            end
        end
    end

    // misses on an empty cache, fills up to a dirty eviction, duplicate fill
    task automatic test_directed();
        send_req(CMD_PROBE, 20'h0, 6'd0, 1'b0, 64'h0);
        send_req(CMD_READ, 20'hfffff, 6'd63, 1'b1, 64'h0);
        send_req(CMD_WRITE, 20'h12345, 6'd63, 1'b0, '1);
        send_req(CMD_FILL, 20'hfffff, 6'd63, 1'b1, '1);
        send_req(CMD_FILL, 20'hfffff, 6'd63, 1'b0, 64'h0);
        send_req(CMD_FILL, 20'h00000, 6'd63, 1'b1, 64'h5555_aaaa_5555_aaaa);
        send_req(CMD_FILL, 20'hfffff, 6'd63, 1'b1, 64'haaaa_5555_aaaa_5555);
        send_req(CMD_PROBE, 20'hfffff, 6'd63, 1'b1, 64'h0);
        send_req(CMD_READ, 20'hfffff, 6'd63, 1'b1, 64'h0);
        send_req(CMD_WRITE, 20'hfffff, 6'd63, 1'b0, 64'h8000_0000_0000_0001);
        send_req(CMD_READ, 20'hfffff, 6'd63, 1'b0, 64'h0);
        send_req(CMD_WRITE, 20'h00000, 6'd63, 1'b1, '1);
        // set is full: these evict by age, dirty victims get reported
        send_req(CMD_FILL, 20'h0abcd, 6'd63, 1'b0, 64'h1);
        send_req(CMD_FILL, 20'h0dcba, 6'd63, 1'b1, 64'h2);
        send_req(CMD_FILL, 20'h11111, 6'd63, 1'b0, 64'h3);
        send_req(CMD_FILL, 20'h22222, 6'd63, 1'b1, 64'h4);
        send_req(CMD_READ, 20'h00000, 6'd63, 1'b1, 64'h0);
        send_req(CMD_PROBE, 20'h11111, 6'd63, 1'b1, 64'h0);
        wait_drained();
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        fork
            begin
                hold_rsp = 1'b1;
                while (hold_cycles < 60) @(negedge i_clk);
                hold_rsp = 1'b0;
                hold_cycles = 0;
            end
            for (int n = 0; n < 12; n++)
                send_req(CMD_FILL, 20'(n), 6'd5, n[0], rand_block());
        join
        wait_drained();
    endtask

    // random commands on a small tag pool, mostly in four sets, so sets fill and evict
    task automatic test_random(int count);
        logic [19:0] tg;
        logic [5:0]  s;
        logic [1:0]  cmd;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 9);
            s = (pick < 8) ? 6'($urandom_range(0, 3)) : 6'($urandom);
            tg = (pick < 9) ? 20'($urandom_range(0, 7)) | (20'($urandom_range(0, 1)) << 19)
                            : 20'($urandom);
            cmd = 2'($urandom_range(0, 3));
            send_req(cmd, tg, s, 1'($urandom), rand_block());
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
        idle_on = 1'b0;
        hold_rsp = 1'b0;
        hold_cycles = 0;
        fail_cnt = 0;
        for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
                sh_valid[s][w] = 1'b0;
                sh_dirty[s][w] = 1'b0;
                sh_kind[s][w] = 1'b0;
                sh_tag[s][w] = '0;
                sh_age[s][w] = '0;
                sh_data[s][w] = '0;
            end
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        idle_on = 1'b1;
        test_backpressure();
        test_random(900);
        idle_on = 1'b0;
        test_random(300);
        repeat (10) @(negedge i_clk);
        if (fail_cnt == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end
endmodule
